FILE: hw/rtl/patch_post_column_blitter_assert.svh
// Assertion macros for the blitter RTL.
`ifndef PATCH_POST_COLUMN_BLITTER_ASSERT_SVH
`define PATCH_POST_COLUMN_BLITTER_ASSERT_SVH

// Checks a property at every rising clock edge outside of reset.
`define PPCB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("blitter assertion failed");

// Checks a property at every rising clock edge, during reset too.
`define PPCB_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("blitter assertion failed");

`endif

FILE: hw/rtl/ppcb_pkg.sv
// Package with the item types, codes and constants of the patch column blitter.
package ppcb_pkg;

  localparam int unsigned ADDR_WIDTH_DEFAULT = 32;
  localparam logic [15:0] ROW_PITCH_RESET    = 16'd640;
  localparam logic [7:0]  END_OF_COLUMN      = 8'hff;

  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_START   = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         pal_index;
    logic [15:0]        pal_color;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] left_offset;
    logic signed [15:0] top_offset;
    logic [7:0]         data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [15:0] pixel_color;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  index;
    logic [15:0] color;
  } pal_wr_t;

  typedef struct packed {
    logic        fire;
    logic [7:0]  pal_index;
    logic [31:0] write_address;
  } pix_req_t;

endpackage

FILE: hw/rtl/ppcb_parser.sv
// Column post parser that tracks the draw addresses and issues pixel requests.
module ppcb_parser #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ppcb_pkg::in_item_t item_i,
  input  logic [15:0]       row_pitch_i,
  output ppcb_pkg::pal_wr_t  pal_wr_o,
  output ppcb_pkg::pix_req_t pix_req_o
);
  import ppcb_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TOP  = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAD  = 3'd3,
    PH_PIX  = 3'd4,
    PH_TAIL = 3'd5
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [ADDR_WIDTH-1:0]   column_base_q, column_base_d;
  logic [ADDR_WIDTH-1:0]   pixel_address_q, pixel_address_d;
  logic [7:0]              pixels_left_q, pixels_left_d;

  logic signed [16:0]      dx;
  logic signed [16:0]      dy;
  logic signed [17:0]      dx2;
  logic signed [33:0]      dy_prod;
  logic [23:0]             row_off;
  logic [7:0]              left_dec;
  logic                    fire;

  assign dx       = $signed({item_i.pos_x[15], item_i.pos_x})
                  - $signed({item_i.left_offset[15], item_i.left_offset});
  assign dy       = $signed({item_i.pos_y[15], item_i.pos_y})
                  - $signed({item_i.top_offset[15], item_i.top_offset});
  assign dx2      = $signed({dx, 1'b0});
  assign dy_prod  = dy * $signed({1'b0, row_pitch_i});
  assign row_off  = item_i.data_byte * row_pitch_i;
  assign left_dec = pixels_left_q - 8'd1;

  always_comb begin
    phase_d         = phase_q;
    column_base_d   = column_base_q;
    pixel_address_d = pixel_address_q;
    pixels_left_d   = pixels_left_q;
    fire            = 1'b0;
    if (accept_i) begin
      case (item_i.kind)
        KIND_START: begin
          column_base_d   = ADDR_WIDTH'(dx2) + ADDR_WIDTH'(dy_prod);
          pixel_address_d = ADDR_WIDTH'(dx2) + ADDR_WIDTH'(dy_prod);
          pixels_left_d   = 8'd0;
          phase_d         = PH_TOP;
        end
        KIND_DATA: begin
          case (phase_q)
            PH_TOP: begin
              if (item_i.data_byte == END_OF_COLUMN) begin
                column_base_d = column_base_q + ADDR_WIDTH'(2);
              end else begin
                pixel_address_d = column_base_q + ADDR_WIDTH'(row_off);
                phase_d         = PH_LEN;
              end
            end
            PH_LEN: begin
              pixels_left_d = item_i.data_byte;
              phase_d       = PH_PAD;
            end
            PH_PAD: begin
              phase_d = (pixels_left_q != 8'd0) ? PH_PIX : PH_TAIL;
            end
            PH_PIX: begin
              fire            = 1'b1;
              pixel_address_d = pixel_address_q + ADDR_WIDTH'(row_pitch_i);
              pixels_left_d   = left_dec;
              if (left_dec == 8'd0) begin
                phase_d = PH_TAIL;
              end
            end
            PH_TAIL: begin
              phase_d = PH_TOP;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      column_base_q   <= '0;
      pixel_address_q <= '0;
      pixels_left_q   <= '0;
    end else begin
      phase_q         <= phase_d;
      column_base_q   <= column_base_d;
      pixel_address_q <= pixel_address_d;
      pixels_left_q   <= pixels_left_d;
    end
  end

  assign pal_wr_o.we    = accept_i && (item_i.kind == KIND_PALETTE);
  assign pal_wr_o.index = item_i.pal_index;
  assign pal_wr_o.color = item_i.pal_color;

  assign pix_req_o.fire          = fire;
  assign pix_req_o.pal_index     = item_i.data_byte;
  assign pix_req_o.write_address = 32'(pixel_address_q);

endmodule

FILE: hw/rtl/patch_post_column_blitter.sv
// Top level of the patch column blitter: palette memory, pixel stage and output register.
`include "patch_post_column_blitter_assert.svh"

// The blitter takes one item in every clock cycle while the input is not
// stalled. Palette items write the 256-entry color memory, a patch start
// item sets the drawing origin, and each data item advances the column post
// parse in the same cycle. A pixel index reads the palette memory at the
// rising edge that accepts the item. Its result moves into the output
// register once the output register is free or being taken. The pixel
// stage can take a new pixel while a result waits in the output register.
// The input stalls only when both hold a pixel and the output is stalled.
// The row pitch must be written through the configuration port only while
// the block is idle, which the block does not enforce; it resets to 640.
module patch_post_column_blitter #(
  parameter int unsigned ADDR_WIDTH = ppcb_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ppcb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ppcb_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import ppcb_pkg::*;

  logic        accept;
  logic        advance;
  logic [15:0] row_pitch_q;
  pal_wr_t     pal_wr;
  pix_req_t    pix_req;

  logic [15:0] palette_mem [256];
  logic [15:0] rdata_q;
  logic        s1_valid_q;
  logic [31:0] s1_addr_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o  = s1_valid_q && out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  ppcb_parser #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .row_pitch_i(row_pitch_q),
    .pal_wr_o   (pal_wr),
    .pix_req_o  (pix_req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pitch_q <= ROW_PITCH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      row_pitch_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_wr.we) begin
      palette_mem[pal_wr.index] <= pal_wr.color;
    end
    if (pix_req.fire) begin
      rdata_q   <= palette_mem[pix_req.pal_index];
      s1_addr_q <= pix_req.write_address;
    end
    if (advance) begin
      out_item_q.write_address <= s1_addr_q;
      out_item_q.pixel_color   <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pix_req.fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `PPCB_ASSERT(a_stall_needs_full, clk_i, rst_ni, in_stall_o |-> s1_valid_q && out_valid_q)
  `PPCB_ASSERT(a_pixel_enters_stage, clk_i, rst_ni, pix_req.fire |=> s1_valid_q)
  `PPCB_ASSERT(a_stage_held, clk_i, rst_ni, s1_valid_q && !advance |=> s1_valid_q)
  `PPCB_ASSERT(a_output_drains, clk_i, rst_ni,
    out_valid_q && !out_stall_i && !s1_valid_q |=> !out_valid_q)
  `PPCB_ASSERT_ALWAYS(a_fire_only_on_accept, clk_i, pix_req.fire |-> accept)

endmodule
